[src/plru_pkg.sv]
// shared types and command codes for the pinned lru slot staging table
package plru_pkg;

    typedef enum logic [2:0] {
        CMD_BEGIN   = 3'd0,
        CMD_RESERVE = 3'd1,
        CMD_DMA     = 3'd2,
        CMD_CONSUME = 3'd3,
        CMD_QUERY   = 3'd4
    } cmd_t;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 24;
    localparam int GEN_W  = 8;

    // request to the recency unit: drop a slot from the order or make it most recent
    typedef struct packed {
        logic en;
        logic touch;
    } order_cmd_t;

endpackage

[src/plru_ram.sv]
// generic single write port ram with registered read
module plru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

[src/plru_order.sv]
// recency order unit: one age cell per slot, drop or touch one slot per cycle
module plru_order #(
    parameter int SLOT_COUNT = 16,
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  plru_pkg::order_cmd_t             op,
    input  logic [SW-1:0]                    op_idx,
    output logic [SLOT_COUNT-1:0]            in_order,
    output logic [SLOT_COUNT-1:0][SW-1:0]    age
);
    import plru_pkg::*;

    logic [SLOT_COUNT-1:0]         in_order_reg, in_order_next;
    logic [SLOT_COUNT-1:0][SW-1:0] age_reg, age_next;
    logic [SW-1:0]                 op_age;
    logic                          op_in;

    assign op_age = age_reg[op_idx];
    assign op_in  = in_order_reg[op_idx];

    always_comb begin
        in_order_next = in_order_reg;
        age_next      = age_reg;
        if (op.en) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (SW'(i) == op_idx) begin
                    age_next[i]      = '0;
                    in_order_next[i] = op.touch;
                end else if (in_order_reg[i]) begin
                    // close the gap left by the slot, then age everyone on a touch
                    age_next[i] = age_reg[i] - SW'(op_in && (age_reg[i] > op_age))
                                  + SW'(op.touch);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_order_reg <= '0;
            age_reg      <= '0;
        end else begin
            in_order_reg <= in_order_next;
            age_reg      <= age_next;
        end
    end

    assign in_order = in_order_reg;
    assign age      = age_reg;
endmodule

[src/pinned_lru_slot_staging_table.sv]
// top level of the pinned lru slot staging table
//
// one command item enters on the s_ channel: cmd on s_tuser, key, need_size,
// pin and rank packed in s_tdata. every item produces exactly one result item
// on the m_ channel: ok, hit, slot_index and assigned_rank in m_tdata.
// the block works on one item at a time; s_tready is high only while idle.
// begin batch, unknown codes and commands refused at decode go straight to
// the output register; dma complete reads its batch slot and stamps the slot,
// and a consume also checks its stamp and hit flag, ending there if one fails.
// reserve, query and a consume that passes both checks then scan the table:
// the tag and capacity ram is read one slot per cycle by a single scan
// sequencer that compares keys and picks the oldest eligible victim, and
// the recency unit updates all ages once per drop or touch.
// the result sits in an output register until m_tready takes it; a stalled
// receiver simply holds the block busy, nothing is lost.
// after reset the table is empty, no slot has been used, batch count and
// generation are zero. the rams need no clearing: every read of a tag,
// batch slot or stamp is qualified by flag registers that reset clears.
module pinned_lru_slot_staging_table #(
    parameter int SLOT_COUNT = 16,
    parameter int BATCH_MAX  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key[63:0], need_size[87:64], pin[88], rank[92:89]
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ok[0], hit[1], slot_index[5:2], assigned_rank[9:6]
);
    import plru_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int BW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int NW = $clog2(BATCH_MAX + 1);
    localparam int TW = KEY_W + SIZE_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DEC  = 7'b0000010,
        ST_BUSE = 7'b0000100,
        ST_CHK  = 7'b0001000,
        ST_SCAN = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] need_reg;
    logic              pin_reg;
    logic [3:0]        rank_reg;

    logic [CW-1:0]     cnt_reg;
    logic              pv_reg;
    logic [SW-1:0]     pidx_reg;
    logic              found_reg;
    logic [SW-1:0]     fidx_reg;
    logic              vfound_reg;
    logic [SW-1:0]     vidx_reg;
    logic [SW-1:0]     vage_reg;
    logic [SIZE_W-1:0] vcap_reg;
    logic [SW-1:0]     s_reg;
    logic [KEY_W-1:0]  tag_s_reg;

    logic [SLOT_COUNT-1:0] busy_reg, res_reg, pinned_reg, indexed_reg, stamp_vld_reg;
    logic [BATCH_MAX-1:0]  was_hit_reg;
    logic [CW-1:0]         fresh_reg;
    logic [NW-1:0]         count_reg;
    logic [GEN_W-1:0]      gen_reg;

    logic       m_tvalid_reg, ok_reg, hit_reg;
    logic [3:0] slot_o_reg, rank_o_reg;

    // rams
    logic          tc_we;
    logic [SW-1:0] tc_waddr, tc_raddr;
    logic [TW-1:0] tc_wdata, tc_rdata;
    logic          bs_we;
    logic [SW-1:0] bs_rdata;
    logic          st_we;
    logic [GEN_W-1:0] st_rdata;

    // recency unit
    order_cmd_t                    ord_op;
    logic [SW-1:0]                 ord_idx;
    logic [SLOT_COUNT-1:0]         in_order;
    logic [SLOT_COUNT-1:0][SW-1:0] age;

    logic [KEY_W-1:0]  cmp_key;
    logic [KEY_W-1:0]  scan_tag;
    logic [SIZE_W-1:0] scan_cap;
    logic              match, cand, dup_drop, accept;
    logic              hit_path, fresh_path, victim_path;
    logic [GEN_W-1:0]  stamp_eff;

    assign accept   = s_tvalid && s_tready;
    assign scan_tag = tc_rdata[KEY_W-1:0];
    assign scan_cap = tc_rdata[TW-1:KEY_W];
    assign cmp_key  = (cmd_reg == CMD_CONSUME) ? tag_s_reg : key_reg;
    assign match    = pv_reg && indexed_reg[pidx_reg] && (scan_tag == cmp_key);
    assign cand     = pv_reg && in_order[pidx_reg] && indexed_reg[pidx_reg]
                      && !busy_reg[pidx_reg] && !pinned_reg[pidx_reg]
                      && res_reg[pidx_reg] && (scan_cap >= need_reg);
    assign dup_drop = (state_reg == ST_SCAN) && (cmd_reg == CMD_CONSUME)
                      && match && (pidx_reg != s_reg);

    assign hit_path    = found_reg;
    assign fresh_path  = !found_reg && (fresh_reg < CW'(SLOT_COUNT));
    assign victim_path = !found_reg && !fresh_path && vfound_reg;

    assign stamp_eff = stamp_vld_reg[s_reg] ? st_rdata : '0;

    // address and write muxes for the rams
    always_comb begin
        tc_raddr = bs_rdata;
        if (state_reg == ST_SCAN) begin
            tc_raddr = (cnt_reg < CW'(SLOT_COUNT)) ? SW'(cnt_reg) : '0;
        end
        tc_we    = (state_reg == ST_FIN) && (cmd_reg == CMD_RESERVE)
                   && (fresh_path || victim_path);
        tc_waddr = fresh_path ? SW'(fresh_reg) : vidx_reg;
        tc_wdata = {(fresh_path ? need_reg : vcap_reg), key_reg};
        bs_we    = (state_reg == ST_FIN) && (cmd_reg == CMD_RESERVE)
                   && (hit_path || fresh_path || victim_path);
        st_we    = (state_reg == ST_BUSE) && (cmd_reg == CMD_DMA);
    end

    // recency unit requests
    always_comb begin
        ord_op  = '0;
        ord_idx = pidx_reg;
        if (dup_drop) begin
            ord_op.en = 1'b1;
        end else if (state_reg == ST_FIN && cmd_reg == CMD_RESERVE) begin
            if (hit_path) begin
                ord_op  = '{en: 1'b1, touch: 1'b1};
                ord_idx = fidx_reg;
            end else if (victim_path) begin
                ord_op.en = 1'b1;
                ord_idx   = vidx_reg;
            end
        end else if (state_reg == ST_FIN && cmd_reg == CMD_CONSUME) begin
            ord_op  = '{en: !in_order[s_reg], touch: 1'b1};
            ord_idx = s_reg;
        end
    end

    plru_ram #(.WIDTH(TW), .DEPTH(SLOT_COUNT)) u_tag_ram (
        .aclk  (aclk),
        .we    (tc_we),
        .waddr (tc_waddr),
        .wdata (tc_wdata),
        .raddr (tc_raddr),
        .rdata (tc_rdata)
    );

    plru_ram #(.WIDTH(SW), .DEPTH(BATCH_MAX)) u_batch_ram (
        .aclk  (aclk),
        .we    (bs_we),
        .waddr (BW'(count_reg)),
        .wdata (hit_path ? fidx_reg : (fresh_path ? SW'(fresh_reg) : vidx_reg)),
        .raddr (BW'(rank_reg)),
        .rdata (bs_rdata)
    );

    plru_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_stamp_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (bs_rdata),
        .wdata (gen_reg),
        .raddr (bs_rdata),
        .rdata (st_rdata)
    );

    plru_order #(.SLOT_COUNT(SLOT_COUNT)) u_order (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (ord_op),
        .op_idx   (ord_idx),
        .in_order (in_order),
        .age      (age)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DEC;
            ST_DEC: begin
                case (cmd_reg)
                    CMD_RESERVE: state_next = (count_reg < NW'(BATCH_MAX)) ? ST_SCAN : ST_OUT;
                    CMD_QUERY:   state_next = ST_SCAN;
                    CMD_DMA, CMD_CONSUME: begin
                        state_next = (NW'(rank_reg) < count_reg
                                      && rank_reg < 4'(BATCH_MAX > 15 ? 15 : BATCH_MAX))
                                     || (BATCH_MAX > 15 && NW'(rank_reg) < count_reg)
                                     ? ST_BUSE : ST_OUT;
                    end
                    default:     state_next = ST_OUT;
                endcase
            end
            ST_BUSE: state_next = (cmd_reg == CMD_CONSUME) ? ST_CHK : ST_OUT;
            ST_CHK: begin
                state_next = (stamp_eff == gen_reg && !was_hit_reg[BW'(rank_reg)])
                             ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: if (cnt_reg == CW'(SLOT_COUNT)) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (m_tvalid_reg && m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            res_reg       <= '0;
            pinned_reg    <= '0;
            indexed_reg   <= '0;
            stamp_vld_reg <= '0;
            was_hit_reg   <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            gen_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            vfound_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg  <= s_tuser;
                        key_reg  <= s_tdata[63:0];
                        need_reg <= s_tdata[87:64];
                        pin_reg  <= s_tdata[88];
                        rank_reg <= s_tdata[92:89];
                    end
                end
                ST_DEC: begin
                    ok_reg     <= (cmd_reg == CMD_BEGIN);
                    hit_reg    <= 1'b0;
                    slot_o_reg <= '0;
                    rank_o_reg <= '0;
                    cnt_reg    <= '0;
                    pv_reg     <= 1'b0;
                    found_reg  <= 1'b0;
                    vfound_reg <= 1'b0;
                    if (cmd_reg == CMD_BEGIN) begin
                        count_reg <= '0;
                        gen_reg   <= gen_reg + GEN_W'(1);
                    end
                    if (state_next == ST_OUT) m_tvalid_reg <= 1'b1;
                end
                ST_BUSE: begin
                    s_reg <= bs_rdata;
                    if (cmd_reg == CMD_DMA) begin
                        stamp_vld_reg[bs_rdata] <= 1'b1;
                        ok_reg       <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                ST_CHK: begin
                    tag_s_reg <= scan_tag;
                    if (stamp_eff == gen_reg) ok_reg <= 1'b1;
                    if (state_next == ST_OUT) m_tvalid_reg <= 1'b1;
                end
                ST_SCAN: begin
                    pv_reg   <= cnt_reg < CW'(SLOT_COUNT);
                    pidx_reg <= (cnt_reg < CW'(SLOT_COUNT)) ? SW'(cnt_reg) : '0;
                    if (cnt_reg < CW'(SLOT_COUNT)) cnt_reg <= cnt_reg + CW'(1);
                    if (match && !found_reg) begin
                        found_reg <= 1'b1;
                        fidx_reg  <= pidx_reg;
                    end
                    // oldest eligible slot, first one wins on equal age
                    if (cand && (!vfound_reg || age[pidx_reg] > vage_reg)) begin
                        vfound_reg <= 1'b1;
                        vidx_reg   <= pidx_reg;
                        vage_reg   <= age[pidx_reg];
                        vcap_reg   <= scan_cap;
                    end
                    if (dup_drop) indexed_reg[pidx_reg] <= 1'b0;
                end
                ST_FIN: begin
                    m_tvalid_reg <= 1'b1;
                    case (cmd_reg)
                        CMD_RESERVE: begin
                            if (hit_path) begin
                                if (pin_reg) pinned_reg[fidx_reg] <= 1'b1;
                            end else if (fresh_path || victim_path) begin
                                busy_reg[tc_waddr]   <= 1'b1;
                                res_reg[tc_waddr]    <= 1'b0;
                                pinned_reg[tc_waddr] <= pin_reg;
                                if (victim_path) indexed_reg[vidx_reg] <= 1'b0;
                                if (fresh_path) fresh_reg <= fresh_reg + CW'(1);
                            end
                            if (hit_path || fresh_path || victim_path) begin
                                was_hit_reg[BW'(count_reg)] <= hit_path;
                                count_reg  <= count_reg + NW'(1);
                                ok_reg     <= 1'b1;
                                hit_reg    <= hit_path;
                                slot_o_reg <= 4'(hit_path ? fidx_reg : tc_waddr);
                                rank_o_reg <= 4'(count_reg);
                            end else begin
                                count_reg <= '0;
                            end
                        end
                        CMD_CONSUME: begin
                            busy_reg[s_reg]    <= 1'b0;
                            res_reg[s_reg]     <= 1'b1;
                            indexed_reg[s_reg] <= 1'b1;
                        end
                        CMD_QUERY: begin
                            ok_reg <= found_reg && res_reg[fidx_reg] && !busy_reg[fidx_reg];
                        end
                        default: ;
                    endcase
                end
                ST_OUT: begin
                    if (m_tready) m_tvalid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, rank_o_reg, slot_o_reg, hit_reg, ok_reg};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_fresh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= CW'(SLOT_COUNT))
        else $error("fresh slot pointer past table");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NW'(BATCH_MAX))
        else $error("batch count past batch size");

    a_gen_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEC && cmd_reg == CMD_BEGIN)
        |=> gen_reg == GEN_W'($past(gen_reg) + GEN_W'(1)))
        else $error("generation not advanced by begin batch");

    a_out_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (state_reg == ST_IDLE && !m_tvalid))
        else $error("block not idle after result taken");
endmodule

[tb/pinned_lru_slot_staging_table_test.sv]
// testbench for the pinned lru slot staging table: directed and random command items checked against a predictor
module pinned_lru_slot_staging_table_test;
    import plru_pkg::*;

    localparam int SLOTS = 16;
    localparam int BMAX  = 16;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] key;
        logic [23:0] need;
        logic        pin;
        logic [3:0]  rank;
    } cmd_item_t;

    typedef struct {
        logic       ok;
        logic       hit;
        logic [3:0] slot;
        logic [3:0] rank;
    } answer_t;

    int errors = 0;

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class table_scoreboard;
        logic [63:0] tag[SLOTS];
        logic [23:0] cap[SLOTS];
        bit busy[SLOTS], res[SLOTS], pinned[SLOTS], idx[SLOTS], ord[SLOTS];
        int age[SLOTS];
        logic [7:0] stamp[SLOTS];
        int fresh;
        int bslot[BMAX];
        bit bhit[BMAX];
        int bcount;
        logic [7:0] gen;
        answer_t pending[$];

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                tag[i] = 0; cap[i] = 0; busy[i] = 0; res[i] = 0; pinned[i] = 0;
                idx[i] = 0; ord[i] = 0; age[i] = 0; stamp[i] = 0;
            end
            for (int i = 0; i < BMAX; i++) begin
                bslot[i] = 0; bhit[i] = 0;
            end
            fresh = 0; bcount = 0; gen = 0;
        endfunction

        function void age_drop(int s);
            if (!ord[s]) return;
            for (int i = 0; i < SLOTS; i++)
                if (ord[i] && age[i] > age[s]) age[i]--;
            ord[s] = 0;
            age[s] = 0;
        endfunction

        function void age_touch(int s);
            age_drop(s);
            for (int i = 0; i < SLOTS; i++)
                if (ord[i]) age[i]++;
            ord[s] = 1;
            age[s] = 0;
        endfunction

        function int lookup(logic [63:0] k);
            for (int i = 0; i < SLOTS; i++)
                if (idx[i] && tag[i] == k) return i;
            return -1;
        endfunction

        function int oldest_victim(logic [23:0] need);
            int best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!ord[i] || !idx[i] || busy[i] || pinned[i] || !res[i]) continue;
                if (cap[i] < need) continue;
                if (best < 0 || age[i] > age[best]) best = i;
            end
            return best;
        endfunction

        function void note_command(cmd_item_t c);
            answer_t a = '{0, 0, 0, 0};
            int s, h;
            case (c.cmd)
                CMD_BEGIN: begin
                    bcount = 0;
                    gen++;
                    a.ok = 1;
                end
                CMD_RESERVE: begin
                    if (bcount < BMAX) begin
                        h = lookup(c.key);
                        s = -1;
                        if (h >= 0) begin
                            s = h;
                            if (c.pin) pinned[s] = 1;
                            age_touch(s);
                        end else begin
                            if (fresh < SLOTS) begin
                                s = fresh;
                                fresh++;
                            end else begin
                                s = oldest_victim(c.need);
                                if (s >= 0) begin
                                    age_drop(s);
                                    idx[s] = 0;
                                end
                            end
                            if (s >= 0) begin
                                if (cap[s] < c.need) cap[s] = c.need;
                                tag[s] = c.key;
                                busy[s] = 1;
                                res[s] = 0;
                                pinned[s] = c.pin;
                            end else bcount = 0;
                        end
                        if (s >= 0) begin
                            bslot[bcount] = s;
                            bhit[bcount] = (h >= 0);
                            a.rank = bcount[3:0];
                            a.slot = s[3:0];
                            a.hit = (h >= 0);
                            a.ok = 1;
                            bcount++;
                        end
                    end
                end
                CMD_DMA: begin
                    if (c.rank < bcount) begin
                        stamp[bslot[c.rank]] = gen;
                        a.ok = 1;
                    end
                end
                CMD_CONSUME: begin
                    if (c.rank < bcount) begin
                        s = bslot[c.rank];
                        if (stamp[s] == gen) begin
                            a.ok = 1;
                            if (!bhit[c.rank]) begin
                                for (int i = 0; i < SLOTS; i++)
                                    if (i != s && idx[i] && tag[i] == tag[s]) begin
                                        idx[i] = 0;
                                        age_drop(i);
                                    end
                                busy[s] = 0;
                                res[s] = 1;
                                idx[s] = 1;
                                if (!ord[s]) age_touch(s);
                            end
                        end
                    end
                end
                CMD_QUERY: begin
                    h = lookup(c.key);
                    if (h >= 0 && res[h] && !busy[h]) a.ok = 1;
                end
                default: ;
            endcase
            pending.insert(pending.size(), a);
        endfunction

        task check_answer(logic [15:0] d);
            answer_t w;
            logic [15:0] wd;
            if (pending.size() == 0) begin
                report("unexpected item", d, 0);
                return;
            end
            w = pending.pop_front();
            wd = {6'd0, w.rank, w.slot, w.hit, w.ok};
            if (d[0] !== w.ok) report("ok", d, wd);
            if (d[1] !== w.hit) report("hit", d, wd);
            if (d[5:2] !== w.slot) report("slot_index", d, wd);
            if (d[9:6] !== w.rank) report("assigned_rank", d, wd);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = 0;
    logic [2:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;

    pinned_lru_slot_staging_table dut (.*);

    always #6 aclk = ~aclk;

    table_scoreboard board = new();
    longint cycles = 0;
    bit calm = 0;
    logic [63:0] key_pool[8];

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) board.check_answer(m_tdata);
    end

    // receiver: random stall per item, ready held while waiting
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            w = calm ? 0 : $urandom_range(0, 19);
            @(negedge aclk);
            if (w != 0) begin
                m_tready <= 0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(cmd_item_t c);
        int w;
        w = calm ? 0 : $urandom_range(0, 19);
        if (w != 0) begin
            s_tvalid <= 0;
            s_tdata <= {$urandom, $urandom, $urandom};
            repeat (w) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= c.cmd;
        s_tdata <= {3'd0, c.rank, c.pin, c.need, c.key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(c);
        @(negedge aclk);
    endtask

    task automatic send_cmd(logic [2:0] cmd, logic [63:0] key, logic [23:0] need,
                            logic pin, logic [3:0] rank);
        cmd_item_t c;
        c.cmd = cmd; c.key = key; c.need = need; c.pin = pin; c.rank = rank;
        send_item(c);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_key();
        return ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [23:0] pick_need();
        case ($urandom_range(0, 3))
            0: return 24'hFFFFFF;
            1: return 0;
            default: return 24'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int n, sent, res_ranks;
        for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 0;
        key_pool[1] = '1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: all commands, rank out of batch, consume before stamp, unknown codes
        send_cmd(CMD_QUERY, 0, 0, 0, 0);
        send_cmd(CMD_DMA, 0, 0, 0, 15);
        send_cmd(CMD_BEGIN, 0, 0, 0, 0);
        send_cmd(CMD_RESERVE, 0, 24'hFFFFFF, 1, 0);
        send_cmd(CMD_RESERVE, '1, 0, 0, 0);
        send_cmd(CMD_CONSUME, 0, 0, 0, 1);
        send_cmd(CMD_DMA, 0, 0, 0, 1);
        send_cmd(CMD_CONSUME, 0, 0, 0, 1);
        send_cmd(CMD_QUERY, '1, 0, 0, 0);
        send_cmd(CMD_RESERVE, '1, 24'hFFFFFF, 1, 0);
        send_cmd(CMD_CONSUME, 0, 0, 0, 2);
        send_cmd(3'd5, '1, '1, 1, 15);
        send_cmd(3'd6, 0, 0, 0, 0);
        send_cmd(3'd7, '1, '1, 1, 15);
        drain();

        // random: mostly well-formed batches of reserve, dma, consume
        sent = 0;
        while (sent < 900) begin
            if (sent > 400 && sent < 420) calm = 1;
            else calm = 0;
            if ($urandom_range(0, 9) == 0) begin
                send_cmd(3'($urandom_range(0, 7)), pick_key(), pick_need(),
                         1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
                sent++;
                continue;
            end
            send_cmd(CMD_BEGIN, 0, 0, 0, 0);
            n = $urandom_range(1, 17);
            res_ranks = 0;
            for (int i = 0; i < n; i++) begin
                send_cmd(CMD_RESERVE, pick_key(), pick_need(), $urandom_range(0, 5) == 0, 0);
                res_ranks++;
            end
            for (int r = 0; r < res_ranks && r < 16; r++) begin
                if ($urandom_range(0, 7) != 0) send_cmd(CMD_DMA, 0, 0, 0, 4'(r));
                send_cmd(CMD_CONSUME, 0, 0, 0, ($urandom_range(0, 9) == 0) ?
                         4'($urandom_range(0, 15)) : 4'(r));
            end
            send_cmd(CMD_QUERY, pick_key(), 0, 0, 0);
            sent += 2 + 3 * n;
            if (sent > 300 && sent < 340) drain();
        end
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
